@@ hdl/imhq_pkg.sv @@
package imhq_pkg;

  localparam int ID_BITS        = 10;
  localparam int ID_SPACE       = 1 << ID_BITS;
  localparam int IN_KEY_BITS    = 32;
  localparam int OUT_KEY_BITS   = 32;
  localparam int WIDE_KEY_BITS  = 64;
  localparam int TOTAL_BITS     = 11;
  localparam int KIND_BITS      = 2;
  localparam int STATUS_BITS    = 3;
  localparam int IN_TDATA_BITS  = 48;
  localparam int IN_TUSER_BITS  = KIND_BITS;
  localparam int OUT_TDATA_BITS = 56;
  localparam int OUT_TUSER_BITS = STATUS_BITS;

  localparam int DEF_CAPACITY   = 1024;
  localparam int DEF_KEY_BITS   = 32;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_PUSH,
    KIND_POP,
    KIND_REMOVE,
    KIND_NOP
  } kind_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK,
    ST_EMPTY,
    ST_ABSENT,
    ST_FULL,
    ST_PRESENT
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_POP_A,
    S_POP_B,
    S_REM_A,
    S_REM_B,
    S_DN_L,
    S_DN_R,
    S_DN_C,
    S_DN_END,
    S_UP_C,
    S_FIN,
    S_DROP,
    S_RESP
  } eng_state_t;

  typedef struct packed {
    kind_t              kind;
    logic [ID_BITS-1:0] id;
  } imhq_req_t;

  typedef struct packed {
    status_t            status;
    logic [ID_BITS-1:0] id;
  } imhq_rsp_t;

endpackage

@@ hdl/imhq_engine.sv @@
module imhq_engine
  import imhq_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY,
  parameter int KEY_BITS = DEF_KEY_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  imhq_req_t                          req,
  input  logic [KEY_BITS-1:0]                req_key,
  output logic                               idle,
  output logic                               done,
  input  logic                               rsp_ready,
  output imhq_rsp_t                          rsp,
  output logic [KEY_BITS-1:0]                rsp_key,
  output logic [$clog2(CAPACITY+1)-1:0]      rsp_total
);

  localparam int PB = $clog2(CAPACITY);
  localparam int CB = $clog2(CAPACITY + 1);
  localparam int XB = PB + 2;
  localparam int EW = KEY_BITS + ID_BITS;

  // heap entries hold id and key together, position table holds held flag and slot
  logic [EW-1:0]   heap_mem [CAPACITY];
  logic [PB:0]     pos_mem  [ID_SPACE];

  logic            heap_we, heap_re, pos_we, pos_re;
  logic [PB-1:0]   heap_waddr, heap_raddr;
  logic [EW-1:0]   heap_wdata;
  logic [ID_BITS-1:0] pos_waddr, pos_raddr;
  logic [PB:0]     pos_wdata;
  logic [EW-1:0]   heap_rd_r;
  logic [PB:0]     pos_rd_r;

  eng_state_t          state_r, state_nxt;
  kind_t               kind_r, kind_nxt;
  logic [CB-1:0]       count_r, count_nxt;
  logic [ID_BITS-1:0]  clr_r, clr_nxt;
  logic [PB-1:0]       p_r, p_nxt;
  logic [ID_BITS-1:0]  mover_id_r, mover_id_nxt;
  logic [KEY_BITS-1:0] mover_key_r, mover_key_nxt;
  logic [ID_BITS-1:0]  left_id_r, left_id_nxt;
  logic [KEY_BITS-1:0] left_key_r, left_key_nxt;
  logic                right_ok_r, right_ok_nxt;
  logic                moved_r, moved_nxt;
  logic [ID_BITS-1:0]  res_id_r, res_id_nxt;
  logic [KEY_BITS-1:0] res_key_r, res_key_nxt;
  status_t             res_status_r, res_status_nxt;

  logic [ID_BITS-1:0]  rd_id;
  logic [KEY_BITS-1:0] rd_key;
  logic                pos_held;
  logic [PB-1:0]       pos_slot;
  logic [CB-1:0]       last_w;
  logic [XB-1:0]       cnt_x, left_x, right_x, new_left_x;
  logic                left_ok, right_ok, new_left_ok;
  logic                pick_right, pick_wins, up_wins, is_full, rem_at_last;
  logic [ID_BITS-1:0]  pick_id;
  logic [KEY_BITS-1:0] pick_key;
  logic [PB-1:0]       pick_pos, parent_pos, push_pos;

  function automatic logic [PB-1:0] parent_of(input logic [PB-1:0] pos);
    logic [PB-1:0] pm1;
    pm1 = pos - 1'b1;
    return pm1 >> 1;
  endfunction

  always_ff @(posedge clk) begin
    if (heap_we) begin
      heap_mem[heap_waddr] <= heap_wdata;
    end
    if (heap_re) begin
      heap_rd_r <= heap_mem[heap_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[pos_waddr] <= pos_wdata;
    end
    if (pos_re) begin
      pos_rd_r <= pos_mem[pos_raddr];
    end
  end

  assign rd_id       = heap_rd_r[ID_BITS-1:0];
  assign rd_key      = heap_rd_r[EW-1:ID_BITS];
  assign pos_held    = pos_rd_r[PB];
  assign pos_slot    = pos_rd_r[PB-1:0];
  assign last_w      = count_r - 1'b1;
  assign push_pos    = count_r[PB-1:0];
  assign is_full     = (count_r >= CB'(CAPACITY));
  assign rem_at_last = (CB'(p_r) == last_w);

  assign cnt_x       = XB'(count_r);
  assign left_x      = XB'({p_r, 1'b1});
  assign right_x     = left_x + 1'b1;
  assign left_ok     = (left_x < cnt_x);
  assign right_ok    = (right_x < cnt_x);

  // right child wins only when strictly greater than the left one
  assign pick_right  = right_ok_r && (rd_key > left_key_r);
  assign pick_id     = pick_right ? rd_id : left_id_r;
  assign pick_key    = pick_right ? rd_key : left_key_r;
  assign pick_pos    = pick_right ? right_x[PB-1:0] : left_x[PB-1:0];
  assign pick_wins   = (pick_key > mover_key_r);
  assign new_left_x  = XB'({pick_pos, 1'b1});
  assign new_left_ok = (new_left_x < cnt_x);

  assign up_wins     = (mover_key_r > rd_key);
  assign parent_pos  = parent_of(p_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_r == ID_BITS'(ID_SPACE - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          unique case (req.kind)
            KIND_PUSH, KIND_REMOVE: state_nxt = S_LOOK;
            KIND_POP:               state_nxt = (count_r == '0) ? S_RESP : S_POP_A;
            KIND_NOP:               state_nxt = S_RESP;
          endcase
        end
      end
      S_LOOK: begin
        if (kind_r == KIND_PUSH) begin
          if (pos_held || is_full) begin
            state_nxt = S_RESP;
          end else begin
            state_nxt = (push_pos == '0) ? S_FIN : S_UP_C;
          end
        end else begin
          state_nxt = pos_held ? S_REM_A : S_RESP;
        end
      end
      S_POP_A:  state_nxt = (count_r == CB'(1)) ? S_DROP : S_POP_B;
      S_POP_B:  state_nxt = S_DN_L;
      S_REM_A:  state_nxt = rem_at_last ? S_DROP : S_REM_B;
      S_REM_B:  state_nxt = S_DN_L;
      S_DN_L:   state_nxt = left_ok ? S_DN_R : S_DN_END;
      S_DN_R:   state_nxt = S_DN_C;
      S_DN_C: begin
        if (pick_wins) begin
          state_nxt = new_left_ok ? S_DN_R : S_FIN;
        end else begin
          state_nxt = S_DN_END;
        end
      end
      S_DN_END: begin
        if (kind_r == KIND_REMOVE && !moved_r && p_r != '0) begin
          state_nxt = S_UP_C;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_UP_C: begin
        if (up_wins && parent_pos != '0) begin
          state_nxt = S_UP_C;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN:    state_nxt = (kind_r == KIND_PUSH) ? S_RESP : S_DROP;
      S_DROP:   state_nxt = S_RESP;
      S_RESP: begin
        if (rsp_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default:  state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    heap_we        = 1'b0;
    heap_waddr     = p_r;
    heap_wdata     = {mover_key_r, mover_id_r};
    heap_re        = 1'b0;
    heap_raddr     = '0;
    pos_we         = 1'b0;
    pos_waddr      = mover_id_r;
    pos_wdata      = {1'b1, p_r};
    pos_re         = 1'b0;
    pos_raddr      = req.id;
    kind_nxt       = kind_r;
    count_nxt      = count_r;
    clr_nxt        = clr_r;
    p_nxt          = p_r;
    mover_id_nxt   = mover_id_r;
    mover_key_nxt  = mover_key_r;
    left_id_nxt    = left_id_r;
    left_key_nxt   = left_key_r;
    right_ok_nxt   = right_ok_r;
    moved_nxt      = moved_r;
    res_id_nxt     = res_id_r;
    res_key_nxt    = res_key_r;
    res_status_nxt = res_status_r;

    unique case (state_r)
      S_CLEAR: begin
        pos_we    = 1'b1;
        pos_waddr = clr_r;
        pos_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
      end
      S_IDLE: begin
        if (start) begin
          kind_nxt       = req.kind;
          mover_id_nxt   = req.id;
          mover_key_nxt  = req_key;
          moved_nxt      = 1'b0;
          res_id_nxt     = '0;
          res_key_nxt    = '0;
          res_status_nxt = ST_OK;
          pos_re         = 1'b1;
          if (req.kind == KIND_POP) begin
            if (count_r == '0) begin
              res_status_nxt = ST_EMPTY;
            end else begin
              heap_re = 1'b1;
            end
          end
        end
      end
      S_LOOK: begin
        if (kind_r == KIND_PUSH) begin
          if (pos_held) begin
            res_status_nxt = ST_PRESENT;
          end else if (is_full) begin
            res_status_nxt = ST_FULL;
          end else begin
            p_nxt      = push_pos;
            count_nxt  = count_r + 1'b1;
            heap_re    = (push_pos != '0);
            heap_raddr = parent_of(push_pos);
          end
        end else begin
          if (!pos_held) begin
            res_status_nxt = ST_ABSENT;
          end else begin
            p_nxt      = pos_slot;
            heap_re    = 1'b1;
            heap_raddr = pos_slot;
          end
        end
      end
      S_POP_A: begin
        res_id_nxt  = rd_id;
        res_key_nxt = rd_key;
        if (count_r == CB'(1)) begin
          count_nxt = '0;
        end else begin
          heap_re    = 1'b1;
          heap_raddr = last_w[PB-1:0];
        end
      end
      S_POP_B: begin
        mover_id_nxt  = rd_id;
        mover_key_nxt = rd_key;
        count_nxt     = last_w;
        p_nxt         = '0;
      end
      S_REM_A: begin
        res_id_nxt  = rd_id;
        res_key_nxt = rd_key;
        if (rem_at_last) begin
          count_nxt = last_w;
        end else begin
          heap_re    = 1'b1;
          heap_raddr = last_w[PB-1:0];
        end
      end
      S_REM_B: begin
        mover_id_nxt  = rd_id;
        mover_key_nxt = rd_key;
        count_nxt     = last_w;
      end
      S_DN_L: begin
        heap_re    = left_ok;
        heap_raddr = left_x[PB-1:0];
      end
      S_DN_R: begin
        left_id_nxt  = rd_id;
        left_key_nxt = rd_key;
        right_ok_nxt = right_ok;
        heap_re      = right_ok;
        heap_raddr   = right_x[PB-1:0];
      end
      S_DN_C: begin
        if (pick_wins) begin
          heap_we    = 1'b1;
          heap_wdata = {pick_key, pick_id};
          pos_we     = 1'b1;
          pos_waddr  = pick_id;
          p_nxt      = pick_pos;
          moved_nxt  = 1'b1;
          heap_re    = new_left_ok;
          heap_raddr = new_left_x[PB-1:0];
        end
      end
      S_DN_END: begin
        heap_re    = (kind_r == KIND_REMOVE && !moved_r && p_r != '0);
        heap_raddr = parent_pos;
      end
      S_UP_C: begin
        if (up_wins) begin
          heap_we    = 1'b1;
          heap_wdata = heap_rd_r;
          pos_we     = 1'b1;
          pos_waddr  = rd_id;
          p_nxt      = parent_pos;
          heap_re    = (parent_pos != '0);
          heap_raddr = parent_of(parent_pos);
        end
      end
      S_FIN: begin
        heap_we = 1'b1;
        pos_we  = 1'b1;
      end
      S_DROP: begin
        pos_we    = 1'b1;
        pos_waddr = res_id_r;
        pos_wdata = '0;
      end
      S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      count_r <= '0;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    p_r          <= p_nxt;
    mover_id_r   <= mover_id_nxt;
    mover_key_r  <= mover_key_nxt;
    left_id_r    <= left_id_nxt;
    left_key_r   <= left_key_nxt;
    right_ok_r   <= right_ok_nxt;
    moved_r      <= moved_nxt;
    res_id_r     <= res_id_nxt;
    res_key_r    <= res_key_nxt;
    res_status_r <= res_status_nxt;
  end

  assign idle       = (state_r == S_IDLE);
  assign done       = (state_r == S_RESP);
  assign rsp.status = res_status_r;
  assign rsp.id     = res_id_r;
  assign rsp_key    = res_key_r;
  assign rsp_total  = count_r;

endmodule

@@ hdl/indexed_max_heap_queue_core.sv @@
// steps to out_tvalid: push looks up the position table, then one compare per level climbed,
// none into an empty heap; pop drops the only entry, else moves the last entry to the root and
// descends; remove drops the last slot, else descends or, if the entry did not move, climbs;
// errors stop after the lookup, empty pop and nop go straight to the response. one item at a
// time, in_tready returns with out_tvalid, later while the output register stalls. synchronous
// active-low reset, then a clear of all 1024 position-table entries with in_tready low.
module indexed_max_heap_queue_core
  import imhq_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY,
  parameter int KEY_BITS = DEF_KEY_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [IN_TDATA_BITS-1:0]  in_tdata,   // item_id, item_key
  input  logic [IN_TUSER_BITS-1:0]  in_tuser,   // kind
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [OUT_TDATA_BITS-1:0] out_tdata,  // out_id, out_key, entry_total
  output logic [OUT_TUSER_BITS-1:0] out_tuser   // status
);

  localparam int CB = $clog2(CAPACITY + 1);

  imhq_req_t                 req;
  imhq_rsp_t                 rsp;
  logic [KEY_BITS-1:0]       req_key, rsp_key;
  logic [CB-1:0]             rsp_total;
  logic [WIDE_KEY_BITS-1:0]  in_key_ext, out_key_ext;
  logic                      eng_idle, eng_done, rsp_ready, start;

  logic                      out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_BITS-1:0] out_tdata_r, out_tdata_nxt;
  logic [OUT_TUSER_BITS-1:0] out_tuser_r, out_tuser_nxt;

  assign in_key_ext = WIDE_KEY_BITS'(in_tdata[ID_BITS +: IN_KEY_BITS]);
  assign req_key    = in_key_ext[KEY_BITS-1:0];
  assign req.kind   = kind_t'(in_tuser[KIND_BITS-1:0]);
  assign req.id     = in_tdata[ID_BITS-1:0];

  assign in_tready  = eng_idle;
  assign start      = in_tvalid && eng_idle;
  assign rsp_ready  = !out_tvalid_r || out_tready;

  imhq_engine #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .req       (req),
    .req_key   (req_key),
    .idle      (eng_idle),
    .done      (eng_done),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .rsp_key   (rsp_key),
    .rsp_total (rsp_total)
  );

  assign out_key_ext = WIDE_KEY_BITS'(rsp_key);

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
    if (eng_done && rsp_ready) begin
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = OUT_TDATA_BITS'({TOTAL_BITS'(rsp_total),
                                        out_key_ext[OUT_KEY_BITS-1:0], rsp.id});
      out_tuser_nxt  = rsp.status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

@@ hdl/imhq_checker.sv @@
module imhq_checker
  import imhq_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tready,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [OUT_TDATA_BITS-1:0] out_tdata,
  input logic [OUT_TUSER_BITS-1:0] out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_OK |-> out_tdata[41:0] == '0)
    else $error("error result carries id or key");

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (CAPACITY > 2047) || (out_tdata[52:42] <= CAPACITY))
    else $error("entry total above capacity");

  a_clear_pass: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !in_tready)
    else $error("input taken during position table clear");

endmodule

bind indexed_max_heap_queue_core imhq_checker #(.CAPACITY(CAPACITY)) u_imhq_checker (.*);

@@ verif/tb_indexed_max_heap_queue_core.sv @@
`timescale 1ns / 100ps

module tb_indexed_max_heap_queue_core
  import imhq_pkg::*;
;

  localparam int HEAP_CAP = DEF_CAPACITY;

  typedef struct {
    logic [ID_BITS-1:0]     id;
    logic [IN_KEY_BITS-1:0] key;
    status_t                status;
    logic [TOTAL_BITS-1:0]  total;
  } heap_result_t;

  class heap_order_board;
    logic [ID_BITS-1:0]     slot_id [HEAP_CAP];
    int unsigned            slot_pos [ID_SPACE];
    bit                     held [ID_SPACE];
    logic [IN_KEY_BITS-1:0] key_of [ID_SPACE];
    int unsigned            held_total;
    heap_result_t           awaited[$];
    int unsigned            fail_count;

    function bit larger(int unsigned a, int unsigned b);
      return key_of[slot_id[a]] > key_of[slot_id[b]];
    endfunction

    function void swap_slots(int unsigned a, int unsigned b);
      logic [ID_BITS-1:0] ia, ib;
      ia = slot_id[a];
      ib = slot_id[b];
      slot_id[a] = ib;
      slot_id[b] = ia;
      slot_pos[ia] = b;
      slot_pos[ib] = a;
    endfunction

    function void climb(int unsigned pos);
      int unsigned parent;
      while (pos > 0) begin
        parent = (pos - 1) / 2;
        if (!larger(pos, parent)) break;
        swap_slots(parent, pos);
        pos = parent;
      end
    endfunction

    // true when the entry moved
    function bit descend(int unsigned start, int unsigned limit);
      int unsigned pos, left, pick;
      pos = start;
      forever begin
        left = 2 * pos + 1;
        if (left >= limit) break;
        pick = left;
        if (left + 1 < limit && larger(left + 1, left)) pick = left + 1;
        if (!larger(pick, pos)) break;
        swap_slots(pos, pick);
        pos = pick;
      end
      return pos > start;
    endfunction

    function logic [ID_BITS-1:0] release_last();
      logic [ID_BITS-1:0] id;
      held_total--;
      id = slot_id[held_total];
      held[id] = 1'b0;
      slot_pos[id] = 0;
      return id;
    endfunction

    function logic [ID_BITS-1:0] random_held();
      if (held_total == 0) return ID_BITS'($urandom);
      return slot_id[$urandom_range(0, held_total - 1)];
    endfunction

    function void note_request(kind_t kind, logic [ID_BITS-1:0] id,
                               logic [IN_KEY_BITS-1:0] key);
      heap_result_t r;
      int unsigned pos, last;
      r.id = '0;
      r.key = '0;
      r.status = ST_OK;
      case (kind)
        KIND_PUSH: begin
          if (held[id]) begin
            r.status = ST_PRESENT;
          end else if (held_total >= HEAP_CAP) begin
            r.status = ST_FULL;
          end else begin
            pos = held_total;
            key_of[id] = key;
            held[id] = 1'b1;
            slot_pos[id] = pos;
            slot_id[pos] = id;
            held_total++;
            climb(pos);
          end
        end
        KIND_POP: begin
          if (held_total == 0) begin
            r.status = ST_EMPTY;
          end else begin
            last = held_total - 1;
            swap_slots(0, last);
            void'(descend(0, last));
            r.id = release_last();
            r.key = key_of[r.id];
          end
        end
        KIND_REMOVE: begin
          if (!held[id] || held_total == 0) begin
            r.status = ST_ABSENT;
          end else begin
            pos = slot_pos[id];
            last = held_total - 1;
            if (pos != last && pos < held_total) begin
              swap_slots(pos, last);
              if (!descend(pos, last)) climb(pos);
            end
            r.id = release_last();
            r.key = key_of[r.id];
          end
        end
        default: ;
      endcase
      r.total = TOTAL_BITS'(held_total);
      awaited = {awaited, r};
    endfunction

    task report(string msg);
      fail_count++;
      if (fail_count <= 40) $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task check_result(logic [ID_BITS-1:0] id, logic [IN_KEY_BITS-1:0] key,
                      status_t status, logic [TOTAL_BITS-1:0] total);
      heap_result_t e;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected result id %0d status %0d", id, status));
        return;
      end
      e = awaited.pop_front();
      if (id !== e.id) report($sformatf("id %0d, expected %0d", id, e.id));
      if (key !== e.key) report($sformatf("key %h, expected %h", key, e.key));
      if (status !== e.status)
        report($sformatf("status %0d, expected %0d", status, e.status));
      if (total !== e.total) report($sformatf("total %0d, expected %0d", total, e.total));
    endtask
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_tvalid;
  logic                      in_tready;
  logic [IN_TDATA_BITS-1:0]  in_tdata;   // item_id, item_key
  logic [IN_TUSER_BITS-1:0]  in_tuser;   // kind
  logic                      out_tvalid;
  logic                      out_tready;
  logic [OUT_TDATA_BITS-1:0] out_tdata;  // out_id, out_key, entry_total
  logic [OUT_TUSER_BITS-1:0] out_tuser;  // status

  heap_order_board board;
  bit              calm;

  indexed_max_heap_queue_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task send_item(kind_t kind, logic [ID_BITS-1:0] id, logic [IN_KEY_BITS-1:0] key);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 14);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'b0, key, id};
    in_tuser <= kind;
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    board.note_request(kind, id, key);
  endtask

  function logic [IN_KEY_BITS-1:0] draw_key(int unsigned style);
    case (style)
      0: return $urandom;
      1: return $urandom_range(0, 3);
      default: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return '1;
          2: return 32'h8000_0000;
          default: return 32'h7fff_ffff;
        endcase
      end
    endcase
  endfunction

  task run_directed();
    send_item(KIND_POP, 10'd0, '0);
    send_item(KIND_REMOVE, 10'd5, '0);
    send_item(KIND_NOP, 10'h3ff, '1);
    send_item(KIND_PUSH, 10'd0, '0);
    send_item(KIND_PUSH, 10'h3ff, '1);
    send_item(KIND_PUSH, 10'd0, 32'd5);
    send_item(KIND_PUSH, 10'd512, 32'h8000_0000);
    send_item(KIND_PUSH, 10'd341, 32'h8000_0000);
    send_item(KIND_PUSH, 10'd682, 32'h5555_5555);
    send_item(KIND_PUSH, 10'd7, 32'haaaa_aaaa);
    send_item(KIND_PUSH, 10'd9, 32'h8000_0000);
    send_item(KIND_REMOVE, 10'd341, '0);
    send_item(KIND_REMOVE, 10'd0, '0);
    send_item(KIND_REMOVE, 10'd7, '0);
    send_item(KIND_POP, 10'h155, '1);
    send_item(KIND_POP, 10'd0, '0);
    send_item(KIND_POP, 10'd0, '0);
    send_item(KIND_POP, 10'd0, '0);
    send_item(KIND_POP, 10'd0, '0);
    send_item(KIND_REMOVE, 10'h3ff, '0);
  endtask

  task run_random();
    int unsigned pattern, key_style, pool, push_cut, r, sub;
    logic [ID_BITS-1:0] id;
    for (int seg = 0; seg < 11; seg++) begin
      pattern = (seg < 4) ? 0 : $urandom_range(0, 2);
      calm = ($urandom_range(0, 3) == 0);
      key_style = $urandom_range(0, 2);
      pool = $urandom_range(0, 1) ? 1023 : 63;
      push_cut = (pattern == 0) ? 68 : ((pattern == 1) ? 48 : 23);
      repeat (50) begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          send_item(KIND_NOP, ID_BITS'($urandom), $urandom);
        end else if (r < 3 + push_cut) begin
          if (r % 10 == 0 && board.held_total > 0) id = board.random_held();
          else id = ID_BITS'($urandom_range(0, pool));
          send_item(KIND_PUSH, id, draw_key(key_style));
        end else begin
          sub = $urandom_range(0, 9);
          if (sub < 4) send_item(KIND_POP, ID_BITS'($urandom), $urandom);
          else if (sub < 9) send_item(KIND_REMOVE, board.random_held(), $urandom);
          else send_item(KIND_REMOVE, ID_BITS'($urandom_range(0, pool)), $urandom);
        end
      end
    end
  endtask

  initial begin
    board = new;
    calm = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = KIND_PUSH;
    out_tready = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    run_directed();
    run_random();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (board.awaited.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (board.fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // result side, with random back-pressure
  initial begin
    int unsigned stall;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      stall = calm ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (out_tvalid !== 1'b1) @(posedge clk);
      board.check_result(out_tdata[9:0], out_tdata[41:10], status_t'(out_tuser),
                         out_tdata[52:42]);
    end
  end

  initial begin
    #3_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
